[rtl/core/ssq_pkg.sv]
// Shared types and constants of the stable sorted priority queue.
package ssq_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned HeldW  = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [KeyW-1:0] entry_key;
    logic [TagW-1:0] entry_tag;
  } in_item_t;

  typedef struct packed {
    logic             out_valid;
    logic [KeyW-1:0]  out_key;
    logic [TagW-1:0]  out_tag;
    logic             dropped;
    logic [HeldW-1:0] held_count;
    logic             is_empty;
  } out_item_t;

  // Contents of one cell.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } slot_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } cmd_t;

endpackage

[rtl/core/ssq_cell.sv]
// One cell of the sorted row: holds a single entry and trades it with its neighbors.
module ssq_cell import ssq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  slot_t left_i,
  input  logic  left_keep_i,
  input  slot_t right_i,
  output slot_t slot_o,
  output logic  keep_o
);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [TagW-1:0] tag_q, tag_d;

  // An entry stays in place on insert when it is not later than the new key.
  assign keep_o = valid_q && (key_q <= cmd_i.key);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (cmd_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          tag_d   = cmd_i.tag;
        end else begin
          valid_d = left_i.valid;
          key_d   = left_i.key;
          tag_d   = left_i.tag;
        end
      end
    end else if (cmd_i.rem) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
      tag_d   = right_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign slot_o = '{valid: valid_q, key: key_q, tag: tag_q};

endmodule

[rtl/core/stable_sorted_priority_queue_unit.sv]
// Top level of the stable sorted priority queue: cell row, count and result register.
//
// Input channel in_valid_i / in_ready_o carries one in_item_t per item: kind
// selects insert or remove, entry_key and entry_tag describe an inserted entry.
// Output channel out_valid_o / out_ready_i carries one out_item_t per item.
// Every accepted item yields exactly one result, in order.
//
// Entries sit in a row of Depth cells sorted by key, earliest at cell 0.
// An insert is broadcast to all cells; each compares its key in parallel and
// either holds, loads the new entry or takes its left neighbor's entry.
// A remove shifts the whole row one cell toward the head.
// Equal keys keep arrival order because a held key equal to the new one stays.
//
// The result is registered: it sits in the output register on the edge
// after acceptance. Throughput is one item per cycle, set by the single
// compare-and-shift step of the cell row. While the output register holds a
// result that the receiver has not taken, in_ready_o is low and the row holds.
// Reset empties the row (all cell valid bits and the count clear) and the
// output register.
module stable_sorted_priority_queue_unit import ssq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic              in_fire;
  logic              full, empty;
  logic [CountW-1:0] count_q, count_d;
  cmd_t              cmd;
  slot_t             slots [Depth];
  logic [Depth-1:0]  keeps;
  logic [Depth-1:0]  valid_vec;
  logic              res_valid_q;
  out_item_t         res_q, res_d;

  assign in_ready_o = !res_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = slots[Depth-1].valid;

  assign cmd.ins = in_fire && (in_item_i.kind == KIND_INSERT) && !full;
  assign cmd.rem = in_fire && (in_item_i.kind == KIND_REMOVE) && !empty;
  assign cmd.key = in_item_i.entry_key;
  assign cmd.tag = in_item_i.entry_tag;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    slot_t left, right;
    logic  left_keep;
    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left      = slots[i-1];
      assign left_keep = keeps[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = slots[i+1];
    end
    ssq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .slot_o      (slots[i]),
      .keep_o      (keeps[i])
    );
    assign valid_vec[i] = slots[i].valid;
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CountW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.dropped    = (in_item_i.kind == KIND_INSERT) && full;
    res_d.held_count = HeldW'(count_d);
    res_d.is_empty   = (count_d == '0);
    if (cmd.rem) begin
      res_d.out_valid = 1'b1;
      res_d.out_key   = slots[0].key;
      res_d.out_tag   = slots[0].tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

  // The count always matches the number of occupied cells.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CountW'($countones(valid_vec)))
    else $error("count differs from occupied cells");

  // Occupied cells form an unbroken run from the head.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + Depth'(1)) & valid_vec) == '0)
    else $error("gap in occupied cells");

  // A remove from a non-empty queue returns the head entry.
  a_remove_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_item_i.kind == KIND_REMOVE) && !empty
    |=> out_item_o.out_valid && (out_item_o.out_key == $past(slots[0].key)))
    else $error("remove did not return head entry");

  // An insert into a full queue is flagged and leaves the count unchanged.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_item_i.kind == KIND_INSERT) && full
    |=> out_item_o.dropped && $stable(count_q))
    else $error("insert into full queue not dropped");

  // Head and second cell stay in key order.
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots[1].valid |-> (slots[0].key <= slots[1].key))
    else $error("head out of order");

endmodule
